>>> design/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
// No dependencies; imported by spq_ram and sorted_priority_queue.
`default_nettype none

package spq_pkg;

   localparam int DATA_W = 32;
   localparam int PRIO_W = 32;
   localparam int OCC_W  = 5;

   // request operation codes
   localparam logic CMD_ENQ = 1'b0;
   localparam logic CMD_DEQ = 1'b1;

   // response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic signed [PRIO_W-1:0] prio;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_ENQ_CMP  = 4'b0010,
      ST_ENQ_PUT  = 4'b0100,
      ST_DEQ_WAIT = 4'b1000
   } state_type;

endpackage

`default_nettype wire

>>> design/sorted_priority_queue.sv
// Sorted priority queue held in a circular entry RAM, smallest priority at the head.
// Dequeue: one RAM read of the head entry, then a registered response. Empty/full rejects skip the RAM.
// Enqueue: the entries behind the new one are each moved back one slot per cycle, read through
//   the RAM read port and written through its separate write port; one request in flight at a time.
// Synchronous reset clears count, head and control; the RAM is not cleared (no sweep).
`default_nettype none

module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic                     req_cmd,
   input  wire logic signed [DATA_W-1:0] req_data_in,
   input  wire logic signed [PRIO_W-1:0] req_prio_in,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic signed [DATA_W-1:0] rsp_data_out,
   output      logic [1:0]               rsp_status,
   output      logic [OCC_W-1:0]         rsp_occupancy,
   output      logic                     rsp_is_empty
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [AW:0]   CAP_W    = (AW+1)'(CAPACITY);
   localparam logic [CW-1:0] CNT_FULL = CW'(CAPACITY);
   localparam logic [AW-1:0] LAST     = AW'(CAPACITY - 1);

   state_type                state_ff, state_in;
   logic [AW-1:0]            head_ff, head_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [AW-1:0]            pos_ff, pos_in;
   entry_type                new_ff, new_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;
   logic [CW-1:0]            rsp_count_ff, rsp_count_in;

   logic          req_acc;
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_wa, ram_ra;
   entry_type     ram_wd, ram_rd;

   // logical slot (0 = head) to RAM address; sum stays below twice the depth
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [AW-1:0] slot);
      logic [AW:0] sum;
      sum = {1'b0, head} + {1'b0, slot};
      if (sum >= CAP_W) begin
         sum = sum - CAP_W;
      end
      return sum[AW-1:0];
   endfunction

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_acc   = req_valid && !req_stall;

   spq_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_ram (
      .clock    (clock),
      .wr_en    (ram_we),
      .wr_addr  (ram_wa),
      .wr_entry (ram_wd),
      .rd_en    (ram_re),
      .rd_addr  (ram_ra),
      .rd_entry (ram_rd)
   );

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      cnt_in        = cnt_ff;
      pos_in        = pos_ff;
      new_in        = new_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      ram_we        = 1'b0;
      ram_wa        = '0;
      ram_wd        = new_ff;
      ram_re        = 1'b0;
      ram_ra        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_cmd == CMD_DEQ) begin
                  if (cnt_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_data_in   = '0;
                     rsp_status_in = STATUS_EMPTY;
                     rsp_count_in  = cnt_ff;
                  end else begin
                     ram_re   = 1'b1;
                     ram_ra   = head_ff;
                     state_in = ST_DEQ_WAIT;
                  end
               end else begin
                  if (cnt_ff == CNT_FULL) begin
                     rsp_valid_in  = 1'b1;
                     rsp_data_in   = '0;
                     rsp_status_in = STATUS_FULL;
                     rsp_count_in  = cnt_ff;
                  end else begin
                     new_in.data = req_data_in;
                     new_in.prio = req_prio_in;
                     pos_in      = AW'(cnt_ff);
                     if (cnt_ff == '0) begin
                        state_in = ST_ENQ_PUT;
                     end else begin
                        ram_re   = 1'b1;
                        ram_ra   = phys(head_ff, AW'(cnt_ff - CW'(1)));
                        state_in = ST_ENQ_CMP;
                     end
                  end
               end
            end
         end

         ST_ENQ_CMP: begin
            // ram_rd holds slot pos-1; a strictly smaller new priority moves it back
            ram_we = 1'b1;
            ram_wa = phys(head_ff, pos_ff);
            if (new_ff.prio < ram_rd.prio) begin
               ram_wd = ram_rd;
               pos_in = pos_ff - AW'(1);
               if (pos_ff == AW'(1)) begin
                  state_in = ST_ENQ_PUT;
               end else begin
                  ram_re = 1'b1;
                  ram_ra = phys(head_ff, pos_ff - AW'(2));
               end
            end else begin
               ram_wd        = new_ff;
               cnt_in        = cnt_ff + CW'(1);
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_status_in = STATUS_OK;
               rsp_count_in  = cnt_ff + CW'(1);
               state_in      = ST_IDLE;
            end
         end

         ST_ENQ_PUT: begin
            ram_we        = 1'b1;
            ram_wa        = phys(head_ff, pos_ff);
            ram_wd        = new_ff;
            cnt_in        = cnt_ff + CW'(1);
            rsp_valid_in  = 1'b1;
            rsp_data_in   = '0;
            rsp_status_in = STATUS_OK;
            rsp_count_in  = cnt_ff + CW'(1);
            state_in      = ST_IDLE;
         end

         ST_DEQ_WAIT: begin
            head_in       = (head_ff == LAST) ? '0 : head_ff + AW'(1);
            cnt_in        = cnt_ff - CW'(1);
            rsp_valid_in  = 1'b1;
            rsp_data_in   = ram_rd.data;
            rsp_status_in = STATUS_OK;
            rsp_count_in  = cnt_ff - CW'(1);
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      new_ff        <= new_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_out  = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = OCC_W'(rsp_count_ff);
   assign rsp_is_empty  = (rsp_count_ff == '0);

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_FULL)
      else $error("entry count above capacity");

   a_ram_write_enq: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_ENQ_CMP || state_ff == ST_ENQ_PUT))
      else $error("RAM written outside an enqueue");

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("request taken while busy");

   a_empty_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_EMPTY) |-> (rsp_is_empty && rsp_data_ff == '0))
      else $error("empty-dequeue response inconsistent");

   a_full_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_FULL) |-> (cnt_ff == CNT_FULL))
      else $error("full response while not full");

   a_deq_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEQ_WAIT) |=> (cnt_ff == $past(cnt_ff) - CW'(1)))
      else $error("dequeue did not drop the count");
`endif

endmodule

`default_nettype wire

>>> design/spq_ram.sv
// Entry store: one write port, one read port, registered read data.
// Depends on spq_pkg for the entry layout.
`default_nettype none

module spq_ram
   import spq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire entry_type     wr_entry,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output      entry_type     rd_entry
);

   entry_type mem_ff [DEPTH];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

`default_nettype wire
